// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL.
// Needs nothing else; included by keyed_alarm_dedup_window, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising edge outside reset
`define KADW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression that must never be true
`define KADW_NEVER(lbl, clk, rst, expr, msg) \
   `KADW_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

// ----- sv/kadw_pkg.sv -----
// Package for the keyed alarm dedup window: sizes, register codes, chain types,
// and the liveness test. No dependencies.
package kadw_pkg;

   localparam int TRACK_ENTRIES = 32;
   localparam int CLASS_COUNT   = 256;

   localparam int TIME_W   = 40;
   localparam int KEY_W    = 32;
   localparam int CLASS_W  = 8;
   localparam int WINDOW_W = 26;   // 65535 s * 1000 fits
   localparam int TRACK_IW = $clog2(TRACK_ENTRIES);
   localparam int CLASS_AW = $clog2(CLASS_COUNT);
   localparam int CLASS_LIM_W = 13;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DEDUP_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACKER_EN     = 2'd1;

   localparam logic [WINDOW_W-1:0] DEFAULT_WINDOW_MS = WINDOW_W'(5000);
   localparam logic [WINDOW_W-1:0] MS_PER_S          = WINDOW_W'(1000);
   localparam logic [CLASS_LIM_W-1:0] CLASS_LIMIT    = CLASS_LIM_W'(CLASS_COUNT);

   // query travelling down the track chain with the running search result
   typedef struct packed {
      logic [TIME_W-1:0]   now;
      logic [KEY_W-1:0]    tid;
      logic                hit;
      logic                free_found;
      logic [TRACK_IW-1:0] free_idx;
      logic [TIME_W-1:0]   old_ts;
      logic [TRACK_IW-1:0] old_idx;
   } token_type;

   // entry update broadcast to every cell
   typedef struct packed {
      logic                en;
      logic [TRACK_IW-1:0] idx;
      logic [KEY_W-1:0]    key;
      logic [TIME_W-1:0]   ts;
   } write_type;

   // entries stamped in the future stay live
   function automatic logic is_live(input logic valid, input logic [TIME_W-1:0] ts,
                                    input logic [TIME_W-1:0] now,
                                    input logic [WINDOW_W-1:0] window);
      logic [TIME_W-1:0] age;
      age = now - ts;
      return valid && ((ts > now) || (age < TIME_W'(window)));
   endfunction

endpackage

// ----- sv/keyed_alarm_dedup_window.sv -----
// Top level of the keyed alarm dedup window: control, class table, track chain.
// Uses kadw_pkg, kadw_ram, kadw_track_cell and assert_macros.svh.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  request | req_timestamp_ms, req_track_id, req_... | start && !busy
//  result  | rsp_keep, rsp_used_track_key, rsp_...   | rsp_valid, one cycle
//  config  | csr_index, csr_data                     | csr_valid && csr_ready
//
// Class-keyed item: table RAM read, then decide and update.
// Track-keyed item: the query walks one cell per cycle down the track chain,
// then the chosen entry is written in the write state.
// Register writes wait while busy or while start is high.
// Reset is synchronous; track and class valid bits clear at once, no sweep.
// The result strobe lasts one cycle; the receiver cannot stall it.
module keyed_alarm_dedup_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [kadw_pkg::TIME_W-1:0]       req_timestamp_ms,
   input  logic [kadw_pkg::KEY_W-1:0]        req_track_id,
   input  logic [kadw_pkg::CLASS_W-1:0]      req_class_id,
   output logic                              rsp_valid,
   output logic                              rsp_keep,
   output logic                              rsp_used_track_key,
   output logic                              rsp_evicted_live,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kadw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kadw_pkg::CSR_DATA_W-1:0]   csr_data
);
   import kadw_pkg::*;
   `include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CLASS = 2'd1;
   localparam logic [1:0] ST_TRACK = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0]              state_ff;
   logic [WINDOW_W-1:0]     window_ff;
   logic                    tracker_en_ff;
   logic                    accept;
   logic                    track_sel;

   // class path
   logic [CLASS_AW-1:0]     cls_addr;
   logic [CLASS_AW-1:0]     cls_addr_ff;
   logic                    cls_in_range;
   logic                    cls_in_range_ff;
   logic [TIME_W-1:0]       now_ff;
   logic [CLASS_COUNT-1:0]  class_valid_ff;
   logic                    cvld_ff;
   logic [TIME_W-1:0]       cls_ts;
   logic                    cls_live;
   logic                    cls_wr;

   // track chain
   logic                    chain_vld [TRACK_ENTRIES+1];
   token_type               chain_tok [TRACK_ENTRIES+1];
   logic [TRACK_ENTRIES-1:0] chain_vld_vec;
   token_type               last_tok;
   logic                    last_vld;
   logic                    wr_en_ff;
   write_type               wr_ff;
   write_type               wr_bus;

   logic                    rsp_valid_ff;
   logic                    rsp_keep_ff;
   logic                    rsp_used_ff;
   logic                    rsp_evict_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   // an item entering in the same cycle must see the old settings throughout
   assign csr_ready = !busy && !start;
   assign track_sel = tracker_en_ff && (req_track_id != '0);

   assign cls_in_range = {{(CLASS_LIM_W-CLASS_W){1'b0}}, req_class_id} < CLASS_LIMIT;
   assign cls_addr     = CLASS_AW'({{(CLASS_LIM_W-CLASS_W){1'b0}}, req_class_id});

   // configuration; the window is formed here so the datapath only compares
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= DEFAULT_WINDOW_MS;
         tracker_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEDUP_INTERVAL: begin
               window_ff <= (csr_data == '0) ? DEFAULT_WINDOW_MS
                          : WINDOW_W'(WINDOW_W'(csr_data) * MS_PER_S);
            end
            CSR_TRACKER_EN: begin
               tracker_en_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // class table: time in RAM, valid bits in flops
   kadw_ram #(
      .WIDTH (TIME_W),
      .DEPTH (CLASS_COUNT)
   ) u_class_ram (
      .clock   (clock),
      .wr_en   (cls_wr),
      .wr_addr (cls_addr_ff),
      .wr_data (now_ff),
      .rd_en   (accept),
      .rd_addr (cls_addr),
      .rd_data (cls_ts)
   );

   assign cls_live = cls_in_range_ff && is_live(cvld_ff, cls_ts, now_ff, window_ff);
   assign cls_wr   = (state_ff == ST_CLASS) && cls_in_range_ff && !cls_live;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_valid_ff <= '0;
      end else if (cls_wr) begin
         class_valid_ff[cls_addr_ff] <= 1'b1;
      end
      if (accept) begin
         cls_addr_ff     <= cls_addr;
         cls_in_range_ff <= cls_in_range;
         now_ff          <= req_timestamp_ms;
         cvld_ff         <= class_valid_ff[cls_addr];
      end
   end

   // track chain: the query enters cell 0 on accept of a track-keyed item
   always_comb begin
      chain_vld[0]            = accept && track_sel;
      chain_tok[0].now        = req_timestamp_ms;
      chain_tok[0].tid        = req_track_id;
      chain_tok[0].hit        = 1'b0;
      chain_tok[0].free_found = 1'b0;
      chain_tok[0].free_idx   = '0;
      chain_tok[0].old_ts     = '1;
      chain_tok[0].old_idx    = '0;
   end

   assign wr_bus    = '{en: wr_en_ff, idx: wr_ff.idx, key: wr_ff.key, ts: wr_ff.ts};

   for (genvar i = 0; i < TRACK_ENTRIES; i++) begin : g_cell
      kadw_track_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (TRACK_IW'(i)),
         .window   (window_ff),
         .in_vld   (chain_vld[i]),
         .in_tok   (chain_tok[i]),
         .out_vld  (chain_vld[i+1]),
         .out_tok  (chain_tok[i+1]),
         .wr       (wr_bus)
      );
      assign chain_vld_vec[i] = chain_vld[i+1];
   end

   assign last_vld = chain_vld[TRACK_ENTRIES];
   assign last_tok = chain_tok[TRACK_ENTRIES];

   // sequencing and result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_en_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         wr_en_ff     <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= track_sel ? ST_TRACK : ST_CLASS;
               end
            end
            ST_CLASS: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_TRACK: begin
               if (last_vld) begin
                  rsp_valid_ff <= 1'b1;
                  wr_en_ff     <= !last_tok.hit;
                  state_ff     <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (state_ff == ST_CLASS) begin
         rsp_keep_ff  <= !cls_live;
         rsp_used_ff  <= 1'b0;
         rsp_evict_ff <= 1'b0;
      end else if (last_vld) begin
         rsp_keep_ff  <= !last_tok.hit;
         rsp_used_ff  <= 1'b1;
         rsp_evict_ff <= !last_tok.hit && !last_tok.free_found;
      end
      if (last_vld) begin
         wr_ff.en  <= 1'b0;
         wr_ff.idx <= last_tok.free_found ? last_tok.free_idx : last_tok.old_idx;
         wr_ff.key <= last_tok.tid;
         wr_ff.ts  <= last_tok.now;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keep           = rsp_keep_ff;
   assign rsp_used_track_key = rsp_used_ff;
   assign rsp_evicted_live   = rsp_evict_ff;

   `KADW_ASSERT(a_one_query, clock, reset, $onehot0(chain_vld_vec),
                "more than one query in the track chain")
   `KADW_ASSERT(a_chain_end, clock, reset, last_vld |-> (state_ff == ST_TRACK),
                "track chain finished outside the track state")
   `KADW_ASSERT(a_write_state, clock, reset, wr_en_ff |-> (state_ff == ST_WRITE),
                "entry write outside the write state")
   `KADW_NEVER(a_evict_class, clock, reset, rsp_valid && rsp_evicted_live && !rsp_used_track_key,
               "eviction reported for a class item")
   `KADW_ASSERT(a_rsp_pulse, clock, reset, rsp_valid |=> !rsp_valid,
                "result strobe longer than one cycle")
endmodule

// ----- sv/kadw_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kadw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ----- sv/kadw_track_cell.sv -----
// One track table entry plus one stage of the search chain.
// Uses kadw_pkg for the token and write types and the liveness test.
module kadw_track_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [kadw_pkg::TRACK_IW-1:0]   cell_idx,
   input  logic [kadw_pkg::WINDOW_W-1:0]   window,
   input  logic                            in_vld,
   input  kadw_pkg::token_type             in_tok,
   output logic                            out_vld,
   output kadw_pkg::token_type             out_tok,
   input  kadw_pkg::write_type             wr
);
   import kadw_pkg::*;

   logic              entry_vld_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [TIME_W-1:0] ts_ff;
   logic              live;
   token_type         tok_in;
   logic              vld_ff;
   token_type         tok_ff;

   always_comb begin
      live   = is_live(entry_vld_ff, ts_ff, in_tok.now, window);
      tok_in = in_tok;
      if (live && (key_ff == in_tok.tid)) begin
         tok_in.hit = 1'b1;
      end
      if (!live && !in_tok.free_found) begin
         tok_in.free_found = 1'b1;
         tok_in.free_idx   = cell_idx;
      end
      // strict compare keeps the lower index on a tie
      if (entry_vld_ff && (ts_ff < in_tok.old_ts)) begin
         tok_in.old_ts  = ts_ff;
         tok_in.old_idx = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= 1'b0;
         vld_ff       <= 1'b0;
      end else begin
         vld_ff <= in_vld;
         if (wr.en && (wr.idx == cell_idx)) begin
            entry_vld_ff <= 1'b1;
         end
      end
      if (wr.en && (wr.idx == cell_idx)) begin
         key_ff <= wr.key;
         ts_ff  <= wr.ts;
      end
      tok_ff <= tok_in;
   end

   assign out_vld = vld_ff;
   assign out_tok = tok_ff;
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for keyed_alarm_dedup_window: directed and random detections,
// predicted by an in-bench copy of the track and class tables. Depends on kadw_pkg and
// the RTL under sv/.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TW   = kadw_pkg::TIME_W;
   localparam int KW   = kadw_pkg::KEY_W;
   localparam int CW   = kadw_pkg::CLASS_W;
   localparam int IW   = kadw_pkg::CSR_IDX_W;
   localparam int DW   = kadw_pkg::CSR_DATA_W;
   localparam int NTRK = kadw_pkg::TRACK_ENTRIES;
   localparam int NCLS = kadw_pkg::CLASS_COUNT;

   localparam logic [TW-1:0] DEFAULT_WIN_MS = TW'(5000);
   localparam logic [TW-1:0] MS_IN_S        = TW'(1000);
   localparam logic [TW-1:0] TIME_MAX       = {TW{1'b1}};
   localparam int            CYCLE_LIMIT    = 500000;
   localparam int            DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic [TW-1:0] ts;
      logic [KW-1:0] tid;
      logic [CW-1:0] cid;
   } detection_type;

   typedef struct packed {
      logic keep;
      logic used_track;
      logic evicted;
   } verdict_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic [TW-1:0] req_timestamp_ms = '0;
   logic [KW-1:0] req_track_id = '0;
   logic [CW-1:0] req_class_id = '0;
   logic          csr_valid = 1'b0;
   logic [IW-1:0] csr_index = kadw_pkg::CSR_DEDUP_INTERVAL;
   logic [DW-1:0] csr_data = '0;
   logic          busy, rsp_valid, rsp_keep, rsp_used_track_key, rsp_evicted_live;
   logic          csr_ready;

   keyed_alarm_dedup_window dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_timestamp_ms   (req_timestamp_ms),
      .req_track_id       (req_track_id),
      .req_class_id       (req_class_id),
      .rsp_valid          (rsp_valid),
      .rsp_keep           (rsp_keep),
      .rsp_used_track_key (rsp_used_track_key),
      .rsp_evicted_live   (rsp_evicted_live),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // dedup tables as the block should hold them
   logic          trk_valid [NTRK];
   logic [KW-1:0] trk_key   [NTRK];
   logic [TW-1:0] trk_time  [NTRK];
   logic          cls_valid [NCLS];
   logic [TW-1:0] cls_time  [NCLS];
   logic [15:0]   interval_s = '0;
   logic          tracker_on = 1'b0;

   detection_type detections_q [$];
   verdict_type   verdict_q [$];
   int            outstanding = 0;
   int            n_errors = 0;
   int unsigned   cycles = 0;
   logic [TW-1:0] cur_time = '0;

   function automatic logic [TW-1:0] window_ms();
      return (interval_s == 0) ? DEFAULT_WIN_MS : TW'(interval_s) * MS_IN_S;
   endfunction

   // entries stamped after now stay live
   function automatic logic entry_live(input logic v, input logic [TW-1:0] t,
                                       input logic [TW-1:0] now,
                                       input logic [TW-1:0] win);
      return v && ((t > now) || ((now - t) < win));
   endfunction

   function automatic verdict_type judge_detection(input detection_type d);
      verdict_type   v;
      logic [TW-1:0] win;
      int            free_slot, oldest, slot;
      logic          hit, live;
      v.keep = 1'b1;
      v.used_track = 1'b0;
      v.evicted = 1'b0;
      win = window_ms();
      if (tracker_on && d.tid != '0) begin
         v.used_track = 1'b1;
         free_slot = -1;
         oldest = 0;
         hit = 1'b0;
         for (int i = 0; i < NTRK; i++) begin
            live = entry_live(trk_valid[i], trk_time[i], d.ts, win);
            if (live && trk_key[i] == d.tid) hit = 1'b1;
            if (!live && free_slot < 0) free_slot = i;
            if (trk_time[i] < trk_time[oldest]) oldest = i;
         end
         if (hit) begin
            v.keep = 1'b0;
         end else begin
            slot = free_slot;
            // table full of live entries: replace the oldest, lowest index on a tie
            if (slot < 0) begin
               slot = oldest;
               v.evicted = 1'b1;
            end
            trk_valid[slot] = 1'b1;
            trk_key[slot] = d.tid;
            trk_time[slot] = d.ts;
         end
      end else if (int'(d.cid) < NCLS) begin
         if (entry_live(cls_valid[d.cid], cls_time[d.cid], d.ts, win)) begin
            v.keep = 1'b0;
         end else begin
            cls_valid[d.cid] = 1'b1;
            cls_time[d.cid] = d.ts;
         end
      end
      return v;
   endfunction

   // sender: bursts of random length separated by random gaps
   detection_type next_det;
   int            burst_left = 0;
   int            gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            verdict_q = {verdict_q, judge_detection({req_timestamp_ms, req_track_id,
                                                     req_class_id})};
         if (!start || !busy) begin
            if (gap_left > 0 || detections_q.size() == 0) begin
               if (gap_left > 0) gap_left--;
               start <= 1'b0;
            end else begin
               next_det = detections_q.pop_front();
               req_timestamp_ms <= next_det.ts;
               req_track_id <= next_det.tid;
               req_class_id <= next_det.cid;
               start <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
               end
            end
         end
      end
   end

   verdict_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (verdict_q.size() == 0) begin
            $error("result with no item waiting");
            n_errors++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_keep !== want.keep) begin
               $error("keep: expected %0d, got %0d", want.keep, rsp_keep);
               n_errors++;
            end
            if (rsp_used_track_key !== want.used_track) begin
               $error("used_track_key: expected %0d, got %0d", want.used_track,
                      rsp_used_track_key);
               n_errors++;
            end
            if (rsp_evicted_live !== want.evicted) begin
               $error("evicted_live: expected %0d, got %0d", want.evicted,
                      rsp_evicted_live);
               n_errors++;
            end
            outstanding--;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic add_detection(input logic [TW-1:0] ts, input logic [KW-1:0] tid,
                                input logic [CW-1:0] cid);
      detection_type d;
      d.ts = ts;
      d.tid = tid;
      d.cid = cid;
      detections_q = {detections_q, d};
      outstanding++;
   endtask

   task automatic drain();
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
      drain();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         kadw_pkg::CSR_DEDUP_INTERVAL: interval_s = val;
         kadw_pkg::CSR_TRACKER_EN:     tracker_on = val[0];
         default: ;
      endcase
   endtask

   task automatic random_phase(input logic [15:0] ival, input logic en, input int count);
      logic [KW-1:0] id_pool [40];
      logic [CW-1:0] cls_pool [8];
      int unsigned   w;
      logic [TW-1:0] step, ts;
      logic [KW-1:0] tid;
      logic [CW-1:0] cid;
      int            r, crowd_left;
      write_reg(kadw_pkg::CSR_DEDUP_INTERVAL, ival);
      write_reg(kadw_pkg::CSR_TRACKER_EN, DW'(en));
      w = 32'(window_ms());
      crowd_left = 0;
      foreach (id_pool[i]) begin
         id_pool[i] = $urandom();
         if (id_pool[i] == '0) id_pool[i] = 1;
      end
      foreach (cls_pool[i]) cls_pool[i] = CW'($urandom_range(0, 255));
      for (int k = 0; k < count; k++) begin
         if (crowd_left == 0 && $urandom_range(0, 99) < 4)
            crowd_left = $urandom_range(30, 40);
         if (crowd_left > 0) begin
            // many fresh keys close together to fill the track table
            crowd_left--;
            step = TW'($urandom_range(0, 1));
            tid = $urandom() | 32'h1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 30) step = '0;
            else if (r < 98) step = TW'($urandom_range(1, w / 128 + 1));
            else if (r < 99) step = TW'($urandom_range(w / 128, w));
            else step = TW'(w) + TW'($urandom_range(0, w));
            r = $urandom_range(0, 9);
            if (r == 0) tid = '0;
            else if (r < 3) tid = $urandom();
            else tid = id_pool[$urandom_range(0, 39)];
         end
         cur_time += step;
         ts = cur_time;
         if ($urandom_range(0, 99) < 3 && cur_time > TW'(2000))
            ts = cur_time - TW'($urandom_range(1, 2000));
         cid = ($urandom_range(0, 9) < 7) ? cls_pool[$urandom_range(0, 7)]
                                          : CW'($urandom_range(0, 255));
         add_detection(ts, tid, cid);
      end
   endtask

   initial begin
      for (int i = 0; i < NTRK; i++) begin
         trk_valid[i] = 1'b0;
         trk_key[i] = '0;
         trk_time[i] = '0;
      end
      for (int i = 0; i < NCLS; i++) begin
         cls_valid[i] = 1'b0;
         cls_time[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // class table at reset settings: window edges and time going backwards
      add_detection(TW'(0), '0, '0);
      add_detection(TW'(0), 32'hFFFF_FFFF, 8'hFF);
      add_detection(TW'(4999), '0, '0);
      add_detection(TW'(5000), '0, '0);
      add_detection(TW'(4999), '0, '0);
      add_detection(TW'(5001), '0, 8'hFF);

      write_reg(kadw_pkg::CSR_TRACKER_EN, DW'(1));
      add_detection(TW'(6000), 32'hFFFF_FFFF, '0);
      add_detection(TW'(6000), '0, 8'hFF);
      add_detection(TW'(10999), 32'hFFFF_FFFF, '0);
      add_detection(TW'(5999), 32'hFFFF_FFFF, 8'h03);
      add_detection(TW'(11000), 32'hFFFF_FFFF, '0);
      add_detection(TW'(11000), 32'h0000_0001, '0);
      add_detection(TW'(11000), 32'h0000_0001, '0);
      add_detection(TW'(11000), 32'h8000_0000, 8'h80);

      write_reg(kadw_pkg::CSR_DEDUP_INTERVAL, DW'(1));
      add_detection(TW'(12000), 32'h0000_0001, '0);
      cur_time = TW'(12000);

      random_phase(16'd0, 1'b1, 180);
      random_phase(16'd1, 1'b1, 150);
      random_phase(16'd65535, 1'b1, 100);
      random_phase(16'd3, 1'b0, 100);
      random_phase(16'd2, 1'b1, 170);

      // top of the time range, default window
      write_reg(kadw_pkg::CSR_DEDUP_INTERVAL, DW'(0));
      write_reg(kadw_pkg::CSR_TRACKER_EN, DW'(1));
      add_detection(TIME_MAX - TW'(5000), '0, 8'h07);
      add_detection(TIME_MAX - TW'(5000), 32'h8000_0000, 8'h07);
      add_detection(TIME_MAX, 32'h8000_0000, 8'h07);
      add_detection(TIME_MAX, '0, 8'h07);
      add_detection(TIME_MAX, '0, 8'h07);
      add_detection(TIME_MAX, 32'hFFFF_FFFF, 8'hFF);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0 && verdict_q.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
